/* src/cpd_pkg.sv */
// Shared types, constants and the CRC-8 update function of the command packet deframer.
package cpd_pkg;

   localparam int unsigned PKT_LEN = 16;
   localparam int unsigned DATA_BYTES = PKT_LEN - 1;
   localparam int unsigned POS_W = 4;
   localparam logic [POS_W-1:0] LAST_POS = 4'd15;
   localparam logic [POS_W-1:0] FIRST_POS = 4'd0;
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'h00;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_start;
   } req_type;

   typedef struct packed {
      logic        crc_ok;
      logic [15:0] cmd_index;
      logic [7:0]  hop_ttl;
      logic [7:0]  command_code;
      logic [23:0] colour_rgb;
      logic [15:0] point_one;
      logic [15:0] point_two;
      logic [23:0] reserved_bytes;
      logic [7:0]  queue_flag;
   } rsp_type;

   // One record handed from the deframer to the result queue.
   typedef struct packed {
      logic    push;
      rsp_type record;
   } rec_push_type;

   // CRC-8, MSB first, one byte folded in per call.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* src/cpd_front.sv */
// Front end: tracks the byte position, the running CRC and the captured bytes, and builds records.
module cpd_front
   import cpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  logic         queue_full,
   output rec_push_type rec_out
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       bytes_ff [DATA_BYTES];
   logic [POS_W-1:0] pos_eff;
   logic [7:0]       crc_eff;
   logic             accept;
   logic             at_last;
   rsp_type          rec;

   // An item at the trailing position needs a free queue slot; others are always taken.
   assign req_ready = !(pos_ff == LAST_POS && queue_full);
   assign accept    = req_valid && req_ready;

   assign pos_eff = req_data.packet_start ? FIRST_POS : pos_ff;
   assign crc_eff = req_data.packet_start ? CRC_INIT : crc_ff;
   assign at_last = (pos_eff == LAST_POS);

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      if (accept) begin
         if (at_last) begin
            pos_in = FIRST_POS;
            crc_in = CRC_INIT;
         end else begin
            pos_in = pos_eff + 4'd1;
            crc_in = crc8_byte(crc_eff, req_data.data_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= FIRST_POS;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !at_last) begin
         bytes_ff[pos_eff] <= req_data.data_byte;
      end
   end

   always_comb begin
      rec.crc_ok         = (req_data.data_byte == crc_eff);
      rec.cmd_index      = {bytes_ff[0], bytes_ff[1]};
      rec.hop_ttl        = bytes_ff[2];
      rec.command_code   = bytes_ff[3];
      rec.colour_rgb     = {bytes_ff[4], bytes_ff[5], bytes_ff[6]};
      rec.point_one      = {bytes_ff[7], bytes_ff[8]};
      rec.point_two      = {bytes_ff[9], bytes_ff[10]};
      rec.reserved_bytes = {bytes_ff[11], bytes_ff[12], bytes_ff[13]};
      rec.queue_flag     = bytes_ff[14];
      // A failed check clears the whole record.
      if (!rec.crc_ok) begin
         rec = '0;
      end
      rec_out.push   = accept && at_last;
      rec_out.record = rec;
   end

endmodule

/* src/cpd_queue.sv */
// Back end: a short record queue whose head drives the result channel.
module cpd_queue
   import cpd_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  rec_push_type rec_in,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   rsp_type       slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == FULL_COUNT);
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign do_push   = rec_in.push;
   assign do_pop    = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= rec_in.record;
      end
   end

endmodule

/* src/command_packet_deframer_crc8_core.sv */
// Top level of the command packet deframer with CRC-8 check.
//
// The req_ channel carries one received byte per item, with packet_start
// marking byte 0 of a 16-byte packet. Bytes 0 to 14 are stored and folded
// into a CRC-8 (polynomial 0x31, initial value zero, MSB first). When the
// trailing byte arrives it is compared with the CRC and one record leaves
// on the rsp_ channel: the unpacked fields with crc_ok set, or all zeros.
// Other items produce no record.
//
// Throughput is one item per cycle while req_ready is high: the CRC
// update of a whole byte is done in the cycle that accepts it. A record
// is written into a small record queue of QUEUE_DEPTH entries when its
// trailing byte is accepted, and rsp_valid presents the queue's head.
//
// If the receiver stalls, bytes 0 to 14 of further packets are still
// accepted; only an item arriving while the byte position is at the
// trailing byte waits, with req_ready low, while the queue is full. This
// includes an item that carries a start flag there. Reset clears the byte
// position, the CRC and the queue; the stored bytes need no clearing, as
// each is written before use.
module command_packet_deframer_crc8_core
   import cpd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rec_push_type rec_push;
   logic         queue_full;

   // Front end: position, CRC and byte capture.
   cpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .rec_out    (rec_push)
   );

   // Back end: records wait here until the receiver takes them.
   cpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .rec_in    (rec_push),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
